// ----- rtl/ckit_pkg.sv -----
// ----------------------------------------------------------------------------
// ckit_pkg: shared types and constants for the key-injection receiver
// Codes, packet-info struct, sequencer states and the byte-wide CRC-32 step.
// ----------------------------------------------------------------------------
package ckit_pkg;

    // opcodes of an input word
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_SWEEP = 2'd1;
    localparam logic [1:0] OP_ROW   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_VERDICT = 2'd0;
    localparam logic [1:0] KIND_SWEEP   = 2'd1;
    localparam logic [1:0] KIND_ROW     = 2'd2;

    // packet verdicts
    localparam logic [2:0] V_NOT_INJECTION = 3'd0;
    localparam logic [2:0] V_BAD_CRC       = 3'd1;
    localparam logic [2:0] V_CLEARED       = 3'd2;
    localparam logic [2:0] V_BAD_USAGE     = 3'd3;
    localparam logic [2:0] V_DOWN          = 3'd4;
    localparam logic [2:0] V_UP            = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_EXPECTED_VERSION = 2'd0;
    localparam logic [1:0] CFG_DEFAULT_TTL      = 2'd1;
    localparam logic [1:0] CFG_MAX_TTL          = 2'd2;

    // reset values of the configuration registers
    localparam logic [7:0]  RST_EXPECTED_VERSION = 8'd18;
    localparam logic [15:0] RST_DEFAULT_TTL      = 16'd500;
    localparam logic [15:0] RST_MAX_TTL          = 16'd1000;

    // command and page codes
    localparam logic [7:0]  CMD_DOWN  = 8'd26;
    localparam logic [7:0]  CMD_UP    = 8'd27;
    localparam logic [7:0]  CMD_CLEAR = 8'd28;
    localparam logic [15:0] KEY_PAGE  = 16'h0007;

    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIN,
        ST_KEY_UPD,
        ST_ROW_OUT,
        ST_SW_ROW,
        ST_SW_BIT,
        ST_SW_WR
    } t_state;

    // header and check status of the packet being received
    typedef struct packed {
        logic        len_ok;
        logic        crc_ok;
        logic [7:0]  version;
        logic [7:0]  command;
        logic [31:0] usage_word;
        logic [15:0] ttl;
    } t_pkt_info;

    // one byte of reflected CRC-32, LSB first
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/ckit_if.sv -----
// ----------------------------------------------------------------------------
// ckit_if: channel interfaces of the key-injection receiver
// Input word, result word and configuration write channels.
// ----------------------------------------------------------------------------
interface ckit_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  byte_value;
    logic        byte_last;
    logic [31:0] now_ms;
    logic [7:0]  row_index;

    modport source (output valid, opcode, byte_value, byte_last, now_ms, row_index,
                    input ready);
    modport sink   (input valid, opcode, byte_value, byte_last, now_ms, row_index,
                    output ready);
endinterface

interface ckit_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [2:0] verdict;
    logic [7:0] expired_count;
    logic [7:0] row_bits;

    modport source (output valid, result_kind, verdict, expired_count, row_bits,
                    input ready);
    modport sink   (input valid, result_kind, verdict, expired_count, row_bits,
                    output ready);
endinterface

interface ckit_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [15:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ----- rtl/ckit_pkt_rx.sv -----
// ----------------------------------------------------------------------------
// ckit_pkt_rx: packet byte absorber
// Byte counter, header fields, running CRC-32 and received CRC of one packet.
// ----------------------------------------------------------------------------
module ckit_pkt_rx #(
    parameter int PACKET_BYTES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_absorb,
    input  logic [7:0]           i_byte,
    input  logic                 i_restart,
    output ckit_pkg::t_pkt_info  o_info
);

    localparam int CW      = $clog2(PACKET_BYTES + 2);
    localparam int CRC_POS = PACKET_BYTES - 4;

    logic [CW-1:0] r_cnt,   n_cnt;
    logic [31:0]   r_crc,   n_crc;
    logic [7:0]    r_ver,   n_ver;
    logic [7:0]    r_cmd,   n_cmd;
    logic [31:0]   r_usage, n_usage;
    logic [15:0]   r_ttl,   n_ttl;
    logic [31:0]   r_rcv,   n_rcv;

    logic [CW-1:0] usage_off;
    logic [CW-1:0] crc_off;
    logic [1:0]    usage_idx;
    logic [1:0]    crc_idx;

    assign usage_off = r_cnt - CW'(2);
    assign crc_off   = r_cnt - CW'(CRC_POS);
    assign usage_idx = usage_off[1:0];
    assign crc_idx   = crc_off[1:0];

    always_comb begin
        n_cnt   = r_cnt;
        n_crc   = r_crc;
        n_ver   = r_ver;
        n_cmd   = r_cmd;
        n_usage = r_usage;
        n_ttl   = r_ttl;
        n_rcv   = r_rcv;
        if (i_restart) begin
            n_cnt   = '0;
            n_crc   = ckit_pkg::CRC_ALL_ONES;
            n_ver   = '0;
            n_cmd   = '0;
            n_usage = '0;
            n_ttl   = '0;
            n_rcv   = '0;
        end else if (i_absorb) begin
            if (r_cnt >= CW'(PACKET_BYTES)) begin
                // overlong packet: count sticks one past the full length
                n_cnt = CW'(PACKET_BYTES + 1);
            end else begin
                if (r_cnt == CW'(0)) begin
                    n_ver = i_byte;
                end else if (r_cnt == CW'(1)) begin
                    n_cmd = i_byte;
                end else if (r_cnt <= CW'(5)) begin
                    n_usage[{usage_idx, 3'b000} +: 8] = r_usage[{usage_idx, 3'b000} +: 8] | i_byte;
                end else if (r_cnt <= CW'(7)) begin
                    n_ttl[{r_cnt[0], 3'b000} +: 8] = r_ttl[{r_cnt[0], 3'b000} +: 8] | i_byte;
                end
                if (r_cnt < CW'(CRC_POS)) begin
                    n_crc = ckit_pkg::crc32_byte(r_crc, i_byte);
                end else begin
                    n_rcv[{crc_idx, 3'b000} +: 8] = r_rcv[{crc_idx, 3'b000} +: 8] | i_byte;
                end
                n_cnt = r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_crc   <= ckit_pkg::CRC_ALL_ONES;
            r_ver   <= '0;
            r_cmd   <= '0;
            r_usage <= '0;
            r_ttl   <= '0;
            r_rcv   <= '0;
        end else begin
            r_cnt   <= n_cnt;
            r_crc   <= n_crc;
            r_ver   <= n_ver;
            r_cmd   <= n_cmd;
            r_usage <= n_usage;
            r_ttl   <= n_ttl;
            r_rcv   <= n_rcv;
        end
    end

    assign o_info.len_ok     = (r_cnt == CW'(PACKET_BYTES));
    assign o_info.crc_ok     = ((r_crc ^ ckit_pkg::CRC_ALL_ONES) == r_rcv);
    assign o_info.version    = r_ver;
    assign o_info.command    = r_cmd;
    assign o_info.usage_word = r_usage;
    assign o_info.ttl        = r_ttl;

endmodule

// ----- rtl/crc_checked_key_injection_ttl.sv -----
// ----------------------------------------------------------------------------
// crc_checked_key_injection_ttl: CRC-checked key injection with key lifetimes
// Receives command packets byte by byte, keeps a pressed-key table and key
// deadlines in block memories, releases expired keys on a sweep word.
// ----------------------------------------------------------------------------
//
//  channel  | dir | modport | words
//  ---------+-----+---------+---------------------------------------------
//  i_in     | in  | sink    | packet byte / sweep / row read
//  o_out    | out | source  | verdict, sweep count or row bits
//  i_cfg    | in  | sink    | register writes, always ready
//
//  Sequencing: a non-final packet byte is absorbed in idle. A final byte passes
//  through the verdict state (and for key down/up a read-modify-write of the
//  pressed row). A row read passes through the row output state. A sweep
//  walks every row: per row one pressed-row read, eight deadline reads
//  through the single deadline read port, one write-back.
//  Reset: synchronous; the pressed table is cleared through per-row valid bits,
//  so there is no clearing pass. Deadline memory needs no reset.
//  Stalls: a word is taken only in idle and only when the output register is
//  free or being drained; a held result blocks every input word, non-final
//  bytes included.
//
module crc_checked_key_injection_ttl #(
    parameter int USAGE_SLOTS  = 256,
    parameter int PACKET_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ckit_in_if.sink     i_in,
    ckit_out_if.source  o_out,
    ckit_cfg_if.sink    i_cfg
);

    localparam int ROW_COUNT = (USAGE_SLOTS + 7) / 8;
    localparam int RW        = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int UW        = $clog2(USAGE_SLOTS);

    // ---------------- configuration registers ----------------
    logic [7:0]  r_exp_ver;
    logic [15:0] r_def_ttl;
    logic [15:0] r_max_ttl;

    assign i_cfg.ready = 1'b1;

    // ---------------- storage ----------------
    // pressed bits, one byte per row; a row with its valid bit low reads zero
    logic [7:0]           r_row_mem [ROW_COUNT];
    logic [ROW_COUNT-1:0] r_row_vld;
    logic [7:0]           r_row_q;
    logic                 r_row_vq;
    // key deadlines; only used for keys whose pressed bit is set
    logic [31:0]          r_dl_mem  [USAGE_SLOTS];
    logic [31:0]          r_dl_q;

    logic          row_we, row_re;
    logic [RW-1:0] row_wa, row_ra;
    logic [7:0]    row_wd;
    logic          dl_we, dl_re;
    logic [UW-1:0] dl_wa, dl_ra;
    logic [31:0]   dl_wd;
    logic          vld_clear;
    logic [7:0]    row_eff;

    // ---------------- sequencer state ----------------
    ckit_pkg::t_state r_state, n_state;
    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_out_kind,  n_out_kind;
    logic [2:0]    r_out_verdict, n_out_verdict;
    logic [7:0]    r_out_count, n_out_count;
    logic [7:0]    r_out_bits,  n_out_bits;
    logic [31:0]   r_now,       n_now;
    logic [RW-1:0] r_key_row,   n_key_row;
    logic [2:0]    r_key_bit,   n_key_bit;
    logic          r_key_down,  n_key_down;
    logic          r_rd_inrange, n_rd_inrange;
    logic [RW-1:0] r_sw_row,    n_sw_row;
    logic [2:0]    r_sw_bit,    n_sw_bit;
    logic [7:0]    r_sw_clr,    n_sw_clr;
    logic [7:0]    r_sw_cnt,    n_sw_cnt;

    logic          in_acc;
    logic          out_load;
    logic          pkt_absorb, pkt_restart;
    ckit_pkg::t_pkt_info info;

    // packet verdict terms
    logic          hdr_bad;
    logic [15:0]   usage16;
    logic [15:0]   usage_row16;
    logic [15:0]   ttl_sel, ttl_cap;
    logic [7:0]    key_mask;
    // sweep terms
    logic [15:0]   sw_u, sw_u_nx;
    logic [2:0]    sw_bit_nx;
    logic [31:0]   sw_diff;
    logic          sw_pressed;

    ckit_pkt_rx #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_pkt_rx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_absorb  (pkt_absorb),
        .i_byte    (i_in.byte_value),
        .i_restart (pkt_restart),
        .o_info    (info)
    );

    assign i_in.ready = (r_state == ckit_pkg::ST_IDLE) && (!r_out_valid || o_out.ready);
    assign in_acc     = i_in.valid && i_in.ready;

    assign o_out.valid         = r_out_valid;
    assign o_out.result_kind   = r_out_kind;
    assign o_out.verdict       = r_out_verdict;
    assign o_out.expired_count = r_out_count;
    assign o_out.row_bits      = r_out_bits;

    assign row_eff = r_row_vq ? r_row_q : 8'd0;

    // verdict decode from the registered packet fields
    assign hdr_bad = !info.len_ok || (info.version != r_exp_ver) ||
                     (info.command < ckit_pkg::CMD_DOWN) || (info.command > ckit_pkg::CMD_CLEAR);
    assign usage16     = info.usage_word[15:0];
    assign usage_row16 = usage16 >> 3;
    assign ttl_sel     = (info.ttl == 16'd0) ? r_def_ttl : info.ttl;
    assign ttl_cap     = (ttl_sel > r_max_ttl) ? r_max_ttl : ttl_sel;
    assign key_mask    = 8'd1 << r_key_bit;

    // sweep usage numbers: current bit and the one being fetched
    assign sw_bit_nx  = r_sw_bit + 3'd1;
    assign sw_u       = (16'(r_sw_row) << 3) | {13'd0, r_sw_bit};
    assign sw_u_nx    = (16'(r_sw_row) << 3) | {13'd0, sw_bit_nx};
    assign sw_diff    = r_now - r_dl_q;
    assign sw_pressed = row_eff[r_sw_bit] && (sw_u != 16'd0) && (sw_u < 16'(USAGE_SLOTS));

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid;
        n_out_kind    = r_out_kind;
        n_out_verdict = r_out_verdict;
        n_out_count   = r_out_count;
        n_out_bits    = r_out_bits;
        n_now         = r_now;
        n_key_row     = r_key_row;
        n_key_bit     = r_key_bit;
        n_key_down    = r_key_down;
        n_rd_inrange  = r_rd_inrange;
        n_sw_row      = r_sw_row;
        n_sw_bit      = r_sw_bit;
        n_sw_clr      = r_sw_clr;
        n_sw_cnt      = r_sw_cnt;
        row_we        = 1'b0;
        row_wa        = '0;
        row_wd        = '0;
        row_re        = 1'b0;
        row_ra        = '0;
        dl_we         = 1'b0;
        dl_wa         = '0;
        dl_wd         = '0;
        dl_re         = 1'b0;
        dl_ra         = '0;
        vld_clear     = 1'b0;
        pkt_absorb    = 1'b0;
        pkt_restart   = 1'b0;
        out_load      = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ckit_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_now = i_in.now_ms;
                    case (i_in.opcode)
                        ckit_pkg::OP_BYTE: begin
                            pkt_absorb = 1'b1;
                            if (i_in.byte_last) begin
                                n_state = ckit_pkg::ST_FIN;
                            end
                        end
                        ckit_pkg::OP_SWEEP: begin
                            n_sw_row = '0;
                            n_sw_cnt = '0;
                            n_state  = ckit_pkg::ST_SW_ROW;
                        end
                        ckit_pkg::OP_ROW: begin
                            row_re       = 1'b1;
                            row_ra       = i_in.row_index[RW-1:0];
                            n_rd_inrange = (i_in.row_index < 8'(ROW_COUNT));
                            n_state      = ckit_pkg::ST_ROW_OUT;
                        end
                        default: ; // unused opcode: dropped
                    endcase
                end
            end

            ckit_pkg::ST_FIN: begin
                pkt_restart = 1'b1;
                out_load    = 1'b1;
                n_state     = ckit_pkg::ST_IDLE;
                if (hdr_bad) begin
                    n_out_verdict = ckit_pkg::V_NOT_INJECTION;
                end else if (!info.crc_ok) begin
                    n_out_verdict = ckit_pkg::V_BAD_CRC;
                end else if (info.command == ckit_pkg::CMD_CLEAR) begin
                    n_out_verdict = ckit_pkg::V_CLEARED;
                    vld_clear     = 1'b1;
                end else if ((info.usage_word[31:16] != ckit_pkg::KEY_PAGE) ||
                             (usage16 == 16'd0) || (usage16 >= 16'(USAGE_SLOTS))) begin
                    n_out_verdict = ckit_pkg::V_BAD_USAGE;
                end else begin
                    // fetch the row, update it next cycle
                    row_re    = 1'b1;
                    row_ra    = usage_row16[RW-1:0];
                    n_key_row = usage_row16[RW-1:0];
                    n_key_bit = usage16[2:0];
                    n_state   = ckit_pkg::ST_KEY_UPD;
                    if (info.command == ckit_pkg::CMD_DOWN) begin
                        n_out_verdict = ckit_pkg::V_DOWN;
                        n_key_down    = 1'b1;
                        dl_we         = 1'b1;
                        dl_wa         = usage16[UW-1:0];
                        dl_wd         = r_now + {16'd0, ttl_cap};
                    end else begin
                        n_out_verdict = ckit_pkg::V_UP;
                        n_key_down    = 1'b0;
                    end
                end
                n_out_kind  = ckit_pkg::KIND_VERDICT;
                n_out_count = '0;
                n_out_bits  = '0;
            end

            ckit_pkg::ST_KEY_UPD: begin
                row_we  = 1'b1;
                row_wa  = r_key_row;
                row_wd  = r_key_down ? (row_eff | key_mask) : (row_eff & ~key_mask);
                n_state = ckit_pkg::ST_IDLE;
            end

            ckit_pkg::ST_ROW_OUT: begin
                out_load      = 1'b1;
                n_out_kind    = ckit_pkg::KIND_ROW;
                n_out_verdict = ckit_pkg::V_NOT_INJECTION;
                n_out_count   = '0;
                n_out_bits    = r_rd_inrange ? row_eff : 8'd0;
                n_state       = ckit_pkg::ST_IDLE;
            end

            ckit_pkg::ST_SW_ROW: begin
                row_re   = 1'b1;
                row_ra   = r_sw_row;
                dl_re    = 1'b1;
                dl_ra    = (16'(r_sw_row) << 3) >> 0 == 16'd0 ? '0 : UW'(16'(r_sw_row) << 3);
                n_sw_bit = '0;
                n_sw_clr = '0;
                n_state  = ckit_pkg::ST_SW_BIT;
            end

            ckit_pkg::ST_SW_BIT: begin
                // deadline of the current bit is in r_dl_q; fetch the next one
                if (sw_pressed && !sw_diff[31]) begin
                    n_sw_clr[r_sw_bit] = 1'b1;
                    n_sw_cnt           = r_sw_cnt + 8'd1;
                end
                if (r_sw_bit == 3'd7) begin
                    n_state = ckit_pkg::ST_SW_WR;
                end else begin
                    dl_re    = 1'b1;
                    dl_ra    = sw_u_nx[UW-1:0];
                    n_sw_bit = sw_bit_nx;
                end
            end

            ckit_pkg::ST_SW_WR: begin
                row_we = 1'b1;
                row_wa = r_sw_row;
                row_wd = row_eff & ~r_sw_clr;
                if (r_sw_row == RW'(ROW_COUNT - 1)) begin
                    out_load      = 1'b1;
                    n_out_kind    = ckit_pkg::KIND_SWEEP;
                    n_out_verdict = ckit_pkg::V_NOT_INJECTION;
                    n_out_count   = r_sw_cnt;
                    n_out_bits    = '0;
                    n_state       = ckit_pkg::ST_IDLE;
                end else begin
                    n_sw_row = r_sw_row + RW'(1);
                    n_state  = ckit_pkg::ST_SW_ROW;
                end
            end

            default: begin
                n_state = ckit_pkg::ST_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ckit_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_row_vld   <= '0;
            r_exp_ver   <= ckit_pkg::RST_EXPECTED_VERSION;
            r_def_ttl   <= ckit_pkg::RST_DEFAULT_TTL;
            r_max_ttl   <= ckit_pkg::RST_MAX_TTL;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (vld_clear) begin
                r_row_vld <= '0;
            end else if (row_we) begin
                r_row_vld[row_wa] <= 1'b1;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.reg_index)
                    ckit_pkg::CFG_EXPECTED_VERSION: r_exp_ver <= i_cfg.wdata[7:0];
                    ckit_pkg::CFG_DEFAULT_TTL:      r_def_ttl <= i_cfg.wdata;
                    ckit_pkg::CFG_MAX_TTL:          r_max_ttl <= i_cfg.wdata;
                    default: ; // no register at this index
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out_kind    <= n_out_kind;
        r_out_verdict <= n_out_verdict;
        r_out_count   <= n_out_count;
        r_out_bits    <= n_out_bits;
        r_now         <= n_now;
        r_key_row     <= n_key_row;
        r_key_bit     <= n_key_bit;
        r_key_down    <= n_key_down;
        r_rd_inrange  <= n_rd_inrange;
        r_sw_row      <= n_sw_row;
        r_sw_bit      <= n_sw_bit;
        r_sw_clr      <= n_sw_clr;
        r_sw_cnt      <= n_sw_cnt;
    end

    // pressed-row memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (row_we) begin
            r_row_mem[row_wa] <= row_wd;
        end
        if (row_re) begin
            r_row_q  <= r_row_mem[row_ra];
            r_row_vq <= r_row_vld[row_ra];
        end
    end

    // deadline memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (dl_we) begin
            r_dl_mem[dl_wa] <= dl_wd;
        end
        if (dl_re) begin
            r_dl_q <= r_dl_mem[dl_ra];
        end
    end

`ifndef SYNTHESIS
    // a result is only loaded into an empty output register
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> !r_out_valid)
        else $error("output register loaded while holding a word");

    // a final packet byte always leads to the verdict cycle
    a_last_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.opcode == ckit_pkg::OP_BYTE && i_in.byte_last)
        |=> r_state == ckit_pkg::ST_FIN)
        else $error("final byte did not reach verdict state");

    // a sweep row is written back only after all eight deadlines were checked
    a_sweep_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ckit_pkg::ST_SW_WR
        |-> ($past(r_state) == ckit_pkg::ST_SW_BIT && $past(r_sw_bit) == 3'd7))
        else $error("sweep write-back before last bit");

    // clear command empties the whole pressed table
    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vld_clear |=> r_row_vld == '0)
        else $error("pressed table not cleared");

    // verdict field is zero on sweep and row words
    a_verdict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != ckit_pkg::KIND_VERDICT)
        |-> r_out_verdict == ckit_pkg::V_NOT_INJECTION)
        else $error("verdict set on a non-verdict word");
`endif

endmodule

// ----- tb/crc_checked_key_injection_ttl_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc_checked_key_injection_ttl_tb: self-checking bench for the key injector
// Feeds command packets, sweeps and row reads through the word channel while
// both sides stall at random. An in-bench key-table model predicts each
// result in order, and every result is compared field by field.
// ----------------------------------------------------------------------------
module crc_checked_key_injection_ttl_tb;
    import ckit_pkg::*;

    localparam int USAGE_SLOTS  = 256;
    localparam int PACKET_BYTES = 32;
    localparam int ROW_COUNT    = USAGE_SLOTS / 8;
    localparam int CRC_START    = PACKET_BYTES - 4;    // first byte of the trailing CRC

    localparam logic [1:0] OP_UNUSED = 2'd3;           // ignored by the block

    localparam int PHASE_WORDS   = 260;                // random words per idling phase
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;                // long receiver hold-off
    localparam int PRINT_LIMIT   = 60;

    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] verdict;
        logic [7:0] expired;
        logic [7:0] row_bits;
    } t_result;

    typedef logic [7:0] t_byte_q [$];

    logic clk;
    logic rst_n;

    ckit_in_if  in_ch();
    ckit_out_if out_ch();
    ckit_cfg_if cfg_ch();

    crc_checked_key_injection_ttl #(
        .USAGE_SLOTS (USAGE_SLOTS),
        .PACKET_BYTES(PACKET_BYTES)
    ) uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    // ------------------------------------------------------------------
    // key table model: configuration, key state and packet assembly
    // ------------------------------------------------------------------
    logic [7:0]             cfg_version;
    logic [15:0]            cfg_default_ttl;
    logic [15:0]            cfg_max_ttl;

    logic [USAGE_SLOTS-1:0] key_map;                   // pressed bit per usage
    logic [31:0]            key_deadline [USAGE_SLOTS];

    logic [31:0]            pkt_crc;
    int                     pkt_len;
    logic [7:0]             pkt_version;
    logic [7:0]             pkt_command;
    logic [31:0]            pkt_usage;
    logic [15:0]            pkt_ttl;
    logic [31:0]            pkt_crc_rx;

    t_result                pending_results [$];       // verdicts/counts/rows not yet seen

    int          mismatch_count = 0;
    int          words_sent     = 0;                   // result-relevant words accepted
    bit          packet_open    = 0;                   // bytes taken since the last final byte
    logic [31:0] clock_ms       = 32'd0;               // bench notion of wall time
    int          src_idle_pct   = 10;
    int          snk_idle_pct   = 10;
    bit          hold_req       = 0;
    int          cycle_count    = 0;

    // bit-serial reflected CRC-32: input bit folded into the feedback
    function automatic logic [31:0] crc_shift(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            c = {1'b0, c[31:1]} ^ ((c[0] ^ b[i]) ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    task automatic restart_packet();
        pkt_crc     = CRC_ALL_ONES;
        pkt_len     = 0;
        pkt_version = '0;
        pkt_command = '0;
        pkt_usage   = '0;
        pkt_ttl     = '0;
        pkt_crc_rx  = '0;
    endtask

    function automatic void clear_key_table();
        key_map = '0;
        foreach (key_deadline[i]) key_deadline[i] = '0;
    endfunction

    task automatic reset_model();
        cfg_version     = RST_EXPECTED_VERSION;
        cfg_default_ttl = RST_DEFAULT_TTL;
        cfg_max_ttl     = RST_MAX_TTL;
        clear_key_table();
        restart_packet();
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        if (pkt_len >= PACKET_BYTES) begin
            pkt_len = PACKET_BYTES + 1;                // saturate, byte dropped
        end else begin
            if (pkt_len == 0) pkt_version = b;
            else if (pkt_len == 1) pkt_command = b;
            else if (pkt_len <= 5) pkt_usage[8*(pkt_len-2) +: 8] = b;
            else if (pkt_len <= 7) pkt_ttl[8*(pkt_len-6) +: 8] = b;
            if (pkt_len < CRC_START) pkt_crc = crc_shift(pkt_crc, b);
            else pkt_crc_rx[8*(pkt_len-CRC_START) +: 8] = b;
            pkt_len++;
        end
    endtask

    // verdict of a finished packet; applies the key command on success
    function automatic logic [2:0] packet_verdict(input logic [31:0] now);
        logic [15:0] usage;
        logic [15:0] ttl;
        if (pkt_len != PACKET_BYTES || pkt_version != cfg_version ||
            pkt_command < CMD_DOWN || pkt_command > CMD_CLEAR)
            return V_NOT_INJECTION;
        if (~pkt_crc != pkt_crc_rx)
            return V_BAD_CRC;
        if (pkt_command == CMD_CLEAR) begin
            clear_key_table();
            return V_CLEARED;
        end
        usage = pkt_usage[15:0];
        if (pkt_usage[31:16] != KEY_PAGE || usage == 0 || usage >= USAGE_SLOTS)
            return V_BAD_USAGE;
        if (pkt_command == CMD_DOWN) begin
            ttl = (pkt_ttl == 0) ? cfg_default_ttl : pkt_ttl;
            if (ttl > cfg_max_ttl) ttl = cfg_max_ttl;
            key_map[usage]      = 1'b1;
            key_deadline[usage] = now + {16'd0, ttl};
            return V_DOWN;
        end
        key_map[usage]      = 1'b0;
        key_deadline[usage] = '0;
        return V_UP;
    endfunction

    // advance the model by one accepted word, queueing any result it causes
    task automatic predict_word(input logic [1:0] op, input logic [7:0] value,
                                input logic last, input logic [31:0] now,
                                input logic [7:0] row);
        t_result     r;
        int          count;
        logic [31:0] age;
        r = '0;
        case (op)
            OP_BYTE: begin
                absorb_byte(value);
                if (last) begin
                    r.kind    = KIND_VERDICT;
                    r.verdict = packet_verdict(now);
                    restart_packet();
                    pending_results.push_back(r);
                end
            end
            OP_SWEEP: begin
                count = 0;
                for (int u = 1; u < USAGE_SLOTS; u++) begin
                    age = now - key_deadline[u];
                    if (key_map[u] && !age[31]) begin  // wrap-safe: deadline reached
                        key_map[u]      = 1'b0;
                        key_deadline[u] = '0;
                        count++;
                    end
                end
                r.kind    = KIND_SWEEP;
                r.expired = count[7:0];
                pending_results.push_back(r);
            end
            OP_ROW: begin
                r.kind = KIND_ROW;
                if (row < ROW_COUNT) r.row_bits = key_map[row*8 +: 8];
                pending_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // clock, watchdog, receiver and result checker
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off counted here on request
    initial begin
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req  = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            if (mismatch_count < PRINT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (pending_results.size() == 0) begin
            if (mismatch_count < PRINT_LIMIT)
                $display("%0t: result with none expected, expected none, actual kind %0d",
                         $time, out_ch.result_kind);
            mismatch_count++;
        end else begin
            want = pending_results.pop_front();
            compare_field("result_kind",   {6'd0, want.kind},    {6'd0, out_ch.result_kind});
            compare_field("verdict",       {5'd0, want.verdict}, {5'd0, out_ch.verdict});
            compare_field("expired_count", want.expired,         out_ch.expired_count);
            compare_field("row_bits",      want.row_bits,        out_ch.row_bits);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            check_result();
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------
    // offer one word, hold it until taken, then predict. valid is left high
    // so that a back-to-back word needs no second assignment in the step.
    task automatic send_word(input logic [1:0] op, input logic [7:0] value,
                             input logic last, input logic [31:0] now,
                             input logic [7:0] row);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= op;
        in_ch.byte_value <= value;
        in_ch.byte_last  <= last;
        in_ch.now_ms     <= now;
        in_ch.row_index  <= row;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        predict_word(op, value, last, now, row);
        if (op == OP_BYTE) packet_open = !last;
        if (op != OP_UNUSED) words_sent++;
    endtask

    // sweep, row read or ignored word; the byte fields carry noise
    task automatic send_control(input logic [1:0] op, input logic [31:0] now,
                                input logic [7:0] row);
        send_word(op, 8'($urandom_range(255)), 1'($urandom_range(1)), now, row);
    endtask

    task automatic send_row(input logic [7:0] row);
        send_control(OP_ROW, $urandom(), row);
    endtask

    task automatic send_sweep(input logic [31:0] now);
        send_control(OP_SWEEP, now, 8'($urandom_range(255)));
    endtask

    // lower valid and wait until every expected result is in
    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= data;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1) @(posedge clk);
        case (idx)
            CFG_EXPECTED_VERSION: cfg_version     = data[7:0];
            CFG_DEFAULT_TTL:      cfg_default_ttl = data;
            CFG_MAX_TTL:          cfg_max_ttl     = data;
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // close any half-sent packet, drain, then load all three registers
    task automatic configure(input logic [7:0] version, input logic [15:0] def_ttl,
                             input logic [15:0] max_ttl);
        if (packet_open) send_word(OP_BYTE, 8'($urandom_range(255)), 1'b1, clock_ms, 8'd0);
        wait_drain();
        write_reg(CFG_EXPECTED_VERSION, {8'd0, version});
        write_reg(CFG_DEFAULT_TTL, def_ttl);
        write_reg(CFG_MAX_TTL, max_ttl);
    endtask

    // 32-byte packet: header, random filler, little-endian CRC trailer
    function automatic t_byte_q make_packet(input logic [7:0] version,
                                            input logic [7:0] command,
                                            input logic [31:0] usage_word,
                                            input logic [15:0] ttl);
        t_byte_q     pkt;
        logic [63:0] hdr;
        logic [31:0] crc;
        hdr = {ttl, usage_word, command, version};
        for (int i = 0; i < 8; i++) pkt.push_back(hdr[8*i +: 8]);
        while (pkt.size() < CRC_START) pkt.push_back(8'($urandom_range(255)));
        crc = CRC_ALL_ONES;
        foreach (pkt[i]) crc = crc_shift(crc, pkt[i]);
        crc = ~crc;
        for (int i = 0; i < 4; i++) pkt.push_back(crc[8*i +: 8]);
        return pkt;
    endfunction

    // send a byte string as one packet; mix_pct slips other words in between
    task automatic send_packet(input t_byte_q pkt, input int mix_pct);
        logic [31:0] stamp;
        foreach (pkt[i]) begin
            if ($urandom_range(99) < mix_pct) begin
                case ($urandom_range(2))
                    0: send_row(8'($urandom_range(ROW_COUNT - 1)));
                    1: send_sweep(clock_ms);
                    default: send_control(OP_UNUSED, $urandom(), 8'($urandom_range(255)));
                endcase
            end
            clock_ms += $urandom_range(2);
            // only the final byte's time counts; others may carry anything
            stamp = (i + 1 < pkt.size() && $urandom_range(3) == 0) ? $urandom() : clock_ms;
            send_word(OP_BYTE, pkt[i], i == pkt.size() - 1, stamp, 8'($urandom_range(255)));
        end
    endtask

    task automatic key_command(input logic [7:0] command, input logic [15:0] usage,
                               input logic [15:0] ttl);
        send_packet(make_packet(cfg_version, command, {KEY_PAGE, usage}, ttl), 0);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_after_reset();
        send_row(8'd0);
        send_row(8'(ROW_COUNT - 1));
        send_row(8'(ROW_COUNT));                       // out of range reads zero
        send_row(8'hFF);
        send_sweep(32'd0);                             // empty table
    endtask

    task automatic test_key_table();
        clock_ms = 32'd1000;
        key_command(CMD_DOWN, 16'd1, 16'd0);           // zero TTL takes the default
        key_command(CMD_DOWN, 16'd255, 16'hFFFF);      // TTL capped at the max
        key_command(CMD_DOWN, 16'd8, 16'd100);
        key_command(CMD_DOWN, 16'd64, 16'd1);
        send_row(8'd0);
        send_row(8'd1);
        send_row(8'(ROW_COUNT - 1));
        key_command(CMD_UP, 16'd8, 16'd0);
        send_row(8'd1);
        send_sweep(clock_ms);                          // usage 64 only
        send_sweep(clock_ms + 32'd1000);               // the rest
        send_row(8'd0);
        key_command(CMD_DOWN, 16'd9, 16'd0);
        key_command(CMD_DOWN, 16'd200, 16'd0);
        key_command(CMD_CLEAR, 16'd0, 16'd0);
        send_row(8'd1);
        send_row(8'd25);
        send_sweep(clock_ms + 32'd5000);
    endtask

    task automatic test_packet_rejects();
        t_byte_q pkt;
        pkt = make_packet(cfg_version, CMD_DOWN, {KEY_PAGE, 16'd5}, 16'd0);
        pkt[CRC_START] ^= 8'h01;                       // corrupted CRC
        send_packet(pkt, 0);
        send_packet(make_packet(cfg_version + 8'd1, CMD_DOWN, {KEY_PAGE, 16'd5}, 16'd0), 0);
        send_packet(make_packet(cfg_version, CMD_DOWN - 8'd1, {KEY_PAGE, 16'd5}, 16'd0), 0);
        send_packet(make_packet(cfg_version, CMD_CLEAR + 8'd1, {KEY_PAGE, 16'd5}, 16'd0), 0);
        pkt = make_packet(cfg_version, CMD_DOWN, {KEY_PAGE, 16'd5}, 16'd0);
        void'(pkt.pop_back());                         // one byte short
        send_packet(pkt, 0);
        pkt = make_packet(cfg_version, CMD_DOWN, {KEY_PAGE, 16'd5}, 16'd0);
        repeat (8) pkt.push_back(8'($urandom_range(255)));   // overlong
        send_packet(pkt, 0);
        pkt = {};
        pkt.push_back(cfg_version);                    // single final byte
        send_packet(pkt, 0);
        send_packet(make_packet(cfg_version, CMD_DOWN, {16'h0006, 16'd5}, 16'd0), 0);
        key_command(CMD_DOWN, 16'd0, 16'd0);           // usage zero
        key_command(CMD_DOWN, 16'h0100, 16'd0);        // usage past the table
        key_command(CMD_UP, 16'hFFFF, 16'd0);
        // other words in the middle of a good packet leave it intact
        send_packet(make_packet(cfg_version, CMD_DOWN, {KEY_PAGE, 16'd17}, 16'd0), 40);
        send_control(OP_UNUSED, $urandom(), 8'd0);
        send_row(8'd2);
    endtask

    task automatic test_deadline_wrap();
        clock_ms = 32'hFFFF_FF00;
        key_command(CMD_DOWN, 16'd3, 16'd512);         // deadline wraps past zero
        send_sweep(32'hFFFF_FFF0);
        send_sweep(32'h0000_0000);
        send_row(8'd0);
        send_sweep(32'h0000_0200);
        send_row(8'd0);
        clock_ms = 32'h0000_0400;
        key_command(CMD_DOWN, 16'd4, 16'd10);
        // half a range past the deadline counts as not yet reached
        send_sweep(key_deadline[4] + 32'h8000_0000);
        send_row(8'd0);
        send_sweep(key_deadline[4] + 32'h7FFF_FFFF);
        send_row(8'd0);
    endtask

    task automatic test_config_extremes();
        configure(8'h00, 16'hFFFF, 16'hFFFF);
        clock_ms = 32'h7FFF_FFF0;
        key_command(CMD_DOWN, 16'd10, 16'd0);
        key_command(CMD_DOWN, 16'd11, 16'hFFFF);
        send_sweep(clock_ms + 32'd60000);
        send_sweep(clock_ms + 32'd70000);
        configure(8'hFF, 16'd1, 16'd1);
        key_command(CMD_DOWN, 16'd12, 16'd0);
        key_command(CMD_DOWN, 16'd13, 16'hFFFF);
        send_packet(make_packet(RST_EXPECTED_VERSION, CMD_CLEAR, 32'd0, 16'd0), 0);
        send_row(8'd1);
        send_sweep(clock_ms + 32'd1);
        configure(RST_EXPECTED_VERSION, 16'd100, 16'd10);  // default above the cap
        key_command(CMD_DOWN, 16'd14, 16'd0);
        send_sweep(clock_ms + 32'd9);
        send_sweep(clock_ms + 32'd10);
    endtask

    // receiver holds off while words keep coming, then the sender waits
    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req     = 1;
        key_command(CMD_DOWN, 16'd30, 16'd0);
        for (int i = 0; i < 40; i++) begin
            if (i % 8 == 7) send_sweep(clock_ms);
            else send_row(8'($urandom_range(ROW_COUNT - 1)));
        end
        key_command(CMD_UP, 16'd30, 16'd0);
        wait_drain();
    endtask

    task automatic send_random_packet();
        t_byte_q     pkt;
        logic [7:0]  command;
        logic [15:0] usage;
        logic [15:0] ttl;
        int          roll;
        roll    = $urandom_range(99);
        command = (roll < 60) ? CMD_DOWN : (roll < 95) ? CMD_UP : CMD_CLEAR;
        // a small hot set of usages so that keys meet again
        usage = ($urandom_range(3) != 0) ? 16'($urandom_range(1, 24))
                                         : 16'($urandom_range(1, USAGE_SLOTS - 1));
        roll = $urandom_range(9);
        ttl  = (roll < 2) ? 16'd0 : (roll < 9) ? 16'($urandom_range(1, 120))
                                               : 16'($urandom_range(16'hFFFF));
        pkt  = make_packet(cfg_version, command, {KEY_PAGE, usage}, ttl);
        send_packet(pkt, 3);
    endtask

    task automatic send_broken_packet();
        t_byte_q pkt;
        int      keep;
        pkt = make_packet(cfg_version, CMD_DOWN, {KEY_PAGE, 16'($urandom_range(1, 24))},
                          16'($urandom_range(60)));
        case ($urandom_range(4))
            0: pkt[$urandom_range(PACKET_BYTES - 1)] ^= 8'(1 << $urandom_range(7));
            1: pkt = make_packet(8'($urandom_range(255)), CMD_DOWN,
                                 {KEY_PAGE, 16'($urandom_range(1, 24))}, 16'd0);
            2: pkt = make_packet(cfg_version, 8'($urandom_range(255)),
                                 {KEY_PAGE, 16'($urandom_range(1, 24))}, 16'd0);
            3: pkt = make_packet(cfg_version, CMD_DOWN - 8'($urandom_range(1)),
                                 ($urandom_range(1) != 0) ? $urandom()
                                 : {KEY_PAGE, 16'($urandom_range(0, 1) << 8)}, 16'd0);
            default: begin
                if ($urandom_range(1) != 0) begin
                    keep = $urandom_range(1, PACKET_BYTES - 1);
                    while (pkt.size() > keep) void'(pkt.pop_back());
                end else begin
                    repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom_range(255)));
                end
            end
        endcase
        send_packet(pkt, 3);
    endtask

    task automatic test_random_phase(input int src_pct, input int snk_pct,
                                     input logic [7:0] version, input logic [15:0] def_ttl,
                                     input logic [15:0] max_ttl);
        int goal;
        int pick;
        configure(version, def_ttl, max_ttl);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        goal = words_sent + PHASE_WORDS;
        while (words_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                send_random_packet();
            end else if (pick < 65) begin
                send_broken_packet();
            end else if (pick < 78) begin
                send_row(($urandom_range(4) != 0) ? 8'($urandom_range(ROW_COUNT + 4))
                                                  : 8'($urandom_range(255)));
            end else if (pick < 90) begin
                clock_ms += $urandom_range(80);
                send_sweep(clock_ms);
            end else if (pick < 96) begin
                // stray byte with any time stamp; may leave a packet open
                send_word(OP_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          $urandom(), 8'($urandom_range(255)));
            end else begin
                send_control(OP_UNUSED, $urandom(), 8'($urandom_range(255)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.opcode     <= OP_BYTE;
        in_ch.byte_value <= 8'd0;
        in_ch.byte_last  <= 1'b0;
        in_ch.now_ms     <= 32'd0;
        in_ch.row_index  <= 8'd0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.reg_index <= CFG_EXPECTED_VERSION;
        cfg_ch.wdata     <= 16'd0;
        reset_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_key_table();
        test_packet_rejects();
        test_deadline_wrap();
        test_config_extremes();
        test_backpressure();
        test_random_phase(18, 79, 8'h5A, 16'd40, 16'd120);
        test_random_phase(79, 18, 8'h81, 16'hFFFF, 16'd90);
        test_random_phase(0, 0, RST_EXPECTED_VERSION, 16'd25, 16'hFFFF);
        wait_drain();

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ckit_pkg.sv
rtl/ckit_if.sv
rtl/ckit_pkt_rx.sv
rtl/crc_checked_key_injection_ttl.sv
tb/crc_checked_key_injection_ttl_tb.sv
